FILE: rtl/vector_refraction_3d_assert.svh
// assertion macros shared by the refraction pipeline
// depends on nothing; included by files that carry concurrent checks
`ifndef VECTOR_REFRACTION_3D_ASSERT_SVH
`define VECTOR_REFRACTION_3D_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define VR3D_CHECK(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("vr3d check failed");

// same with a caller message
`define VR3D_CHECK_MSG(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

`endif

FILE: rtl/vr3d_pkg.sv
// shared constants, stage payload types and the square root step
// depends on nothing; used by every module of the refraction pipeline
package vr3d_pkg;

	localparam int FRAC = 14;
	localparam int HALF = 1 << (FRAC - 1);
	localparam int ONE = 1 << FRAC;

	// radicand, root and remainder widths of the integer square root
	localparam int RAD_W = 40;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int SQ_STEPS = 4;
	localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

	// cycles from accepted item to done strobe
	localparam int LATENCY = 6 + SQ_STAGES + 2;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic tir;
		logic signed [22:0] edr;
		logic signed [32:0] er_x;
		logic signed [32:0] er_y;
		logic signed [32:0] er_z;
		logic signed [15:0] n_x;
		logic signed [15:0] n_y;
		logic signed [15:0] n_z;
	} vr3d_mid_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} vr3d_sq_t;

	// one restoring step: two radicand bits in, one root bit out
	function automatic vr3d_sq_t sqrt_step(input vr3d_sq_t s);
		vr3d_sq_t o;
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		cur = {s.rem, s.rad[RAD_W-1 -: 2]};
		trial = {2'b00, s.root, 2'b01};
		o.rad = {s.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			o.rem = REM_W'(cur - trial);
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem = REM_W'(cur);
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

FILE: rtl/vr3d_front.sv
// front half: dot product, eta squared and the k term, six register stages
// depends on vr3d_pkg
module vr3d_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [15:0] ray_x,
	input  logic signed [15:0] ray_y,
	input  logic signed [15:0] ray_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic [15:0] index_ratio,
	output logic out_valid,
	output vr3d_pkg::vr3d_mid_t out_data
);

	logic [5:0] vld_q;

	// stage 1: products
	logic signed [31:0] p_x_s1, p_y_s1, p_z_s1;
	logic [31:0] eta2_s1;
	logic signed [32:0] er_x_s1, er_y_s1, er_z_s1;
	logic signed [15:0] n_x_s1, n_y_s1, n_z_s1;
	logic [15:0] eta_s1;
	// stage 2
	logic signed [19:0] d_s2;
	logic [18:0] e2_s2;
	logic signed [32:0] er_x_s2, er_y_s2, er_z_s2;
	logic signed [15:0] n_x_s2, n_y_s2, n_z_s2;
	logic [15:0] eta_s2;
	// stage 3
	logic signed [39:0] dsq_s3;
	logic signed [36:0] ed_s3;
	logic [18:0] e2_s3;
	logic signed [32:0] er_x_s3, er_y_s3, er_z_s3;
	logic signed [15:0] n_x_s3, n_y_s3, n_z_s3;
	// stage 4
	logic signed [26:0] t_s4;
	logic signed [22:0] edr_s4;
	logic [18:0] e2_s4;
	logic signed [32:0] er_x_s4, er_y_s4, er_z_s4;
	logic signed [15:0] n_x_s4, n_y_s4, n_z_s4;
	// stage 5
	logic signed [46:0] et_s5;
	logic signed [22:0] edr_s5;
	logic signed [32:0] er_x_s5, er_y_s5, er_z_s5;
	logic signed [15:0] n_x_s5, n_y_s5, n_z_s5;
	// stage 6
	vr3d_pkg::vr3d_mid_t mid_s6;

	logic signed [33:0] dotw;
	logic signed [33:0] dotw_r;
	logic [32:0] eta2_r;
	logic signed [39:0] dsq_r;
	logic signed [36:0] ed_r;
	logic signed [25:0] dd;
	logic signed [46:0] et_r;
	logic signed [33:0] k;

	always_comb begin
		dotw = 34'(p_x_s1) + 34'(p_y_s1) + 34'(p_z_s1);
		dotw_r = dotw + 34'(vr3d_pkg::HALF);
		eta2_r = 33'(eta2_s1) + 33'(vr3d_pkg::HALF);
		dsq_r = dsq_s3 + 40'(vr3d_pkg::HALF);
		ed_r = ed_s3 + 37'(vr3d_pkg::HALF);
		dd = 26'(dsq_r >>> vr3d_pkg::FRAC);
		et_r = et_s5 + 47'(vr3d_pkg::HALF);
		// k is one minus the rounded product of eta squared and t, with no clamp
		k = 34'(vr3d_pkg::ONE) - 34'(et_r >>> vr3d_pkg::FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		p_x_s1 <= ray_x * norm_x;
		p_y_s1 <= ray_y * norm_y;
		p_z_s1 <= ray_z * norm_z;
		eta2_s1 <= index_ratio * index_ratio;
		er_x_s1 <= $signed({1'b0, index_ratio}) * ray_x;
		er_y_s1 <= $signed({1'b0, index_ratio}) * ray_y;
		er_z_s1 <= $signed({1'b0, index_ratio}) * ray_z;
		n_x_s1 <= norm_x;
		n_y_s1 <= norm_y;
		n_z_s1 <= norm_z;
		eta_s1 <= index_ratio;

		d_s2 <= 20'(dotw_r >>> vr3d_pkg::FRAC);
		e2_s2 <= 19'(eta2_r >> vr3d_pkg::FRAC);
		er_x_s2 <= er_x_s1;
		er_y_s2 <= er_y_s1;
		er_z_s2 <= er_z_s1;
		n_x_s2 <= n_x_s1;
		n_y_s2 <= n_y_s1;
		n_z_s2 <= n_z_s1;
		eta_s2 <= eta_s1;

		dsq_s3 <= d_s2 * d_s2;
		ed_s3 <= $signed({1'b0, eta_s2}) * d_s2;
		e2_s3 <= e2_s2;
		er_x_s3 <= er_x_s2;
		er_y_s3 <= er_y_s2;
		er_z_s3 <= er_z_s2;
		n_x_s3 <= n_x_s2;
		n_y_s3 <= n_y_s2;
		n_z_s3 <= n_z_s2;

		t_s4 <= 27'(vr3d_pkg::ONE) - 27'(dd);
		edr_s4 <= 23'(ed_r >>> vr3d_pkg::FRAC);
		e2_s4 <= e2_s3;
		er_x_s4 <= er_x_s3;
		er_y_s4 <= er_y_s3;
		er_z_s4 <= er_z_s3;
		n_x_s4 <= n_x_s3;
		n_y_s4 <= n_y_s3;
		n_z_s4 <= n_z_s3;

		et_s5 <= $signed({1'b0, e2_s4}) * t_s4;
		edr_s5 <= edr_s4;
		er_x_s5 <= er_x_s4;
		er_y_s5 <= er_y_s4;
		er_z_s5 <= er_z_s4;
		n_x_s5 <= n_x_s4;
		n_y_s5 <= n_y_s4;
		n_z_s5 <= n_z_s4;

		mid_s6.tir <= k[33];
		mid_s6.rad <= k[33] ? '0 : {k[25:0], {vr3d_pkg::FRAC{1'b0}}};
		mid_s6.edr <= edr_s5;
		mid_s6.er_x <= er_x_s5;
		mid_s6.er_y <= er_y_s5;
		mid_s6.er_z <= er_z_s5;
		mid_s6.n_x <= n_x_s5;
		mid_s6.n_y <= n_y_s5;
		mid_s6.n_z <= n_z_s5;
	end

	assign out_valid = vld_q[5];
	assign out_data = mid_s6;

endmodule

FILE: rtl/vr3d_sqrt.sv
// pipelined integer square root of the radicand, four root bits per stage
// depends on vr3d_pkg
module vr3d_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  vr3d_pkg::vr3d_mid_t in_data,
	output logic out_valid,
	output vr3d_pkg::vr3d_mid_t out_data,
	output logic [vr3d_pkg::ROOT_W-1:0] root
);

	localparam int NS = vr3d_pkg::SQ_STAGES;

	logic [NS-1:0] vld_q;
	vr3d_pkg::vr3d_sq_t sq_q [NS];
	vr3d_pkg::vr3d_mid_t pay_q [NS];
	vr3d_pkg::vr3d_sq_t nxt [NS];

	always_comb begin
		vr3d_pkg::vr3d_sq_t s;
		for (int i = 0; i < NS; i++) begin
			if (i == 0) begin
				s.rad = in_data.rad;
				s.rem = '0;
				s.root = '0;
			end else begin
				s = sq_q[i-1];
			end
			for (int j = 0; j < vr3d_pkg::SQ_STEPS; j++) begin
				s = vr3d_pkg::sqrt_step(s);
			end
			nxt[i] = s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NS; i++) begin
			sq_q[i] <= nxt[i];
			pay_q[i] <= (i == 0) ? in_data : pay_q[(i == 0) ? 0 : i-1];
		end
	end

	assign out_valid = vld_q[NS-1];
	assign out_data = pay_q[NS-1];
	assign root = sq_q[NS-1].root;

endmodule

FILE: rtl/vr3d_back.sv
// back half: scale the normal, subtract, round and saturate, two stages
// depends on vr3d_pkg
module vr3d_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  vr3d_pkg::vr3d_mid_t in_data,
	input  logic [vr3d_pkg::ROOT_W-1:0] root,
	output logic done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic total_reflect,
	output logic saturated
);

	logic vld_s1, vld_s2;
	logic signed [39:0] mn_x_s1, mn_y_s1, mn_z_s1;
	logic signed [32:0] er_x_s1, er_y_s1, er_z_s1;
	logic tir_s1;
	logic signed [23:0] m;
	logic signed [15:0] o_x, o_y, o_z;
	logic c_x, c_y, c_z;

	function automatic logic signed [16:0] sat_rnd(input logic signed [32:0] er,
		input logic signed [39:0] mn);
		logic signed [40:0] diff;
		logic signed [26:0] v;
		logic signed [15:0] o;
		logic clip;
		diff = 41'(er) - 41'(mn) + 41'(vr3d_pkg::HALF);
		v = 27'(diff >>> vr3d_pkg::FRAC);
		clip = 1'b1;
		if (v > 27'sd32767) begin
			o = 16'sh7fff;
		end else if (v < -27'sd32768) begin
			o = 16'sh8000;
		end else begin
			o = 16'(v);
			clip = 1'b0;
		end
		return {clip, o};
	endfunction

	always_comb begin
		m = 24'(in_data.edr) + 24'($signed({1'b0, root}));
		{c_x, o_x} = sat_rnd(er_x_s1, mn_x_s1);
		{c_y, o_y} = sat_rnd(er_y_s1, mn_y_s1);
		{c_z, o_z} = sat_rnd(er_z_s1, mn_z_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mn_x_s1 <= m * in_data.n_x;
		mn_y_s1 <= m * in_data.n_y;
		mn_z_s1 <= m * in_data.n_z;
		er_x_s1 <= in_data.er_x;
		er_y_s1 <= in_data.er_y;
		er_z_s1 <= in_data.er_z;
		tir_s1 <= in_data.tir;

		out_x <= tir_s1 ? '0 : o_x;
		out_y <= tir_s1 ? '0 : o_y;
		out_z <= tir_s1 ? '0 : o_z;
		total_reflect <= tir_s1;
		saturated <= !tir_s1 && (c_x || c_y || c_z);
	end

	assign done = vld_s2;

endmodule

FILE: rtl/vector_refraction_3d.sv
// glsl style 3d refraction, fully pipelined through the front, square root
// and back sections to the done strobe, one item accepted every cycle
// busy is tied low since results cannot be held off and nothing stalls
// reset clears the valid chain only; payload registers are not reset
// depends on vr3d_pkg, vr3d_front, vr3d_sqrt, vr3d_back
`include "vector_refraction_3d_assert.svh"
module vector_refraction_3d (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [15:0] ray_x,
	input  logic signed [15:0] ray_y,
	input  logic signed [15:0] ray_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic [15:0] index_ratio,
	output logic done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic total_reflect,
	output logic saturated
);

	// item valid into and between the three sections
	logic acc;
	logic mid_valid, sq_valid;
	vr3d_pkg::vr3d_mid_t mid_data, sq_data;
	logic [vr3d_pkg::ROOT_W-1:0] root;

	// never stalls: every cycle can take a new item
	assign busy = 1'b0;
	assign acc = start && !busy;

	// dot product, eta squared and k; radicand is k scaled up, zero on reflection
	vr3d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (acc),
		.ray_x      (ray_x),
		.ray_y      (ray_y),
		.ray_z      (ray_z),
		.norm_x     (norm_x),
		.norm_y     (norm_y),
		.norm_z     (norm_z),
		.index_ratio(index_ratio),
		.out_valid  (mid_valid),
		.out_data   (mid_data)
	);

	// truncating square root, four root bits per stage
	vr3d_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_data  (mid_data),
		.out_valid(sq_valid),
		.out_data (sq_data),
		.root     (root)
	);

	// eta*ray minus m*normal, rounded and clipped to 16 bits
	vr3d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (sq_valid),
		.in_data      (sq_data),
		.root         (root),
		.done         (done),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.total_reflect(total_reflect),
		.saturated    (saturated)
	);

	// each accepted item shows up exactly at the fixed latency
	`VR3D_CHECK(a_latency, clk, arst_n, acc |-> ##(vr3d_pkg::LATENCY) done)
	// reflection forces a zero vector and no clipping
	`VR3D_CHECK_MSG(a_tir_zero, clk, arst_n,
		(done && total_reflect) |-> (out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0 && !saturated),
		"reflected item not zero")
	// a strobe with no item behind it
	`VR3D_CHECK(a_no_phantom, clk, arst_n, done |-> $past(acc, vr3d_pkg::LATENCY))

endmodule
